// ===== rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the floppy controller port block.
// No dependencies; the image RAM, response queue and core files import this package.
package fdc_pkg;

  // Default disk geometry
  localparam int TRACK_COUNT_DEF  = 77;
  localparam int SECTOR_COUNT_DEF = 32;
  localparam int SECTOR_BYTES_DEF = 137;

  // Fixed field widths
  localparam int TRACK_W     = 7;
  localparam int SECTOR_W    = 5;
  localparam int BPOS_W      = 8;
  localparam int DATA_W      = 8;
  localparam int NUM_DRIVES  = 2;
  localparam int QUEUE_DEPTH = 4;

  // Drive select codes
  localparam logic [1:0] SEL_DRIVE0 = 2'd0;
  localparam logic [1:0] SEL_NONE   = 2'd2;

  // Bus operations and port numbers
  localparam logic       OP_IN     = 1'b0;
  localparam logic       OP_OUT    = 1'b1;
  localparam logic [7:0] PORT_SEL  = 8'h08;
  localparam logic [7:0] PORT_SECT = 8'h09;
  localparam logic [7:0] PORT_DATA = 8'h0A;

  // Fixed data patterns
  localparam logic [7:0] FILL_BYTE    = 8'hE5;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] STATUS_RESET = 8'hCC;
  localparam logic [1:0] SECT_HIGH    = 2'b11;
  localparam logic [3:0] SEL_FIELD_MASK = 4'hF;

  // Status register bit positions
  localparam int ST_HEAD_BIT = 2;
  localparam int ST_CR_BIT   = 3;
  localparam int ST_IE_BIT   = 5;
  localparam int ST_T0_BIT   = 6;
  localparam int ST_NRDA_BIT = 7;

  // Function command bit positions
  localparam int FN_IN_BIT     = 0;
  localparam int FN_OUT_BIT    = 1;
  localparam int FN_LOAD_BIT   = 2;
  localparam int FN_UNLOAD_BIT = 3;
  localparam int FN_IE_BIT     = 4;
  localparam int FN_ID_BIT     = 5;
  localparam int FN_WE_BIT     = 7;

  // Configuration register index (address bit 2)
  localparam logic REG_DRIVE_PRESENT = 1'b0;

  // Per-drive register set
  typedef struct packed {
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic [7:0]          status;
    logic [BPOS_W-1:0]   bpos;
    logic                wen;
    logic [TRACK_W-1:0]  ltrack;
    logic [SECTOR_W-1:0] lsector;
    logic                modf;
  } drv_t;

  localparam drv_t DRV_RESET = '{
    track:   '0,
    sector:  '0,
    status:  STATUS_RESET,
    bpos:    '0,
    wen:     1'b0,
    ltrack:  '0,
    lsector: '0,
    modf:    1'b0
  };

  // Response beat
  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic [NUM_DRIVES-1:0] dirty_mask;
  } rsp_t;

endpackage

// ===== rtl/fdc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for bus access requests and responses.
// Standalone; widths match the fields in fdc_pkg.
interface fdc_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] port;
  logic [7:0] write_data;

  modport source (output valid, output operation, output port, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input port, input write_data,
                  output ready);
endinterface

interface fdc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] dirty_mask;

  modport source (output valid, output read_data, output dirty_mask, input ready);
  modport sink   (input valid, input read_data, input dirty_mask, output ready);
endinterface

// ===== rtl/fdc_image_ram.sv =====
`timescale 1ns / 1ps
// Single-drive sector image memory: one write and one read per cycle,
// registered read data, and a fill pass after reset. Uses fdc_pkg.
module fdc_image_ram #(
  parameter  int Depth = 2,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          addr_i,
  input  logic [fdc_pkg::DATA_W-1:0] wdata_i,
  output logic [fdc_pkg::DATA_W-1:0] rdata_o,
  output logic                      busy_o
);
  import fdc_pkg::*;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rdata_q;
  logic              busy_q;
  logic [AddrW-1:0]  fill_addr_q;

  logic              mem_we;
  logic [AddrW-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_wdata;

  // Fill pass owns the port until every entry holds the blank pattern
  assign mem_we    = busy_q | we_i;
  assign mem_addr  = busy_q ? fill_addr_q : addr_i;
  assign mem_wdata = busy_q ? FILL_BYTE : wdata_i;

  // Fill pass sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      fill_addr_q <= '0;
    end else if (busy_q) begin
      if (fill_addr_q == AddrW'(Depth - 1)) begin
        busy_q <= 1'b0;
      end else begin
        fill_addr_q <= fill_addr_q + 1'b1;
      end
    end
  end

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (re_i && !busy_q) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ===== rtl/fdc_rsp_queue.sv =====
`timescale 1ns / 1ps
// Small response queue that decouples the access pipeline from the
// response channel. Uses fdc_pkg and fdc_rsp_if.
module fdc_rsp_queue #(
  parameter  int Depth = 4,
  localparam int PtrW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fdc_pkg::rsp_t   push_data_i,
  output logic [PtrW:0]   count_o,
  fdc_rsp_if.source       rsp_o
);
  import fdc_pkg::*;

  rsp_t            buf_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;
  rsp_t            head;

  assign pop  = rsp_o.valid && rsp_o.ready;
  assign head = buf_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign rsp_o.valid      = (cnt_q != '0);
  assign rsp_o.read_data  = head.read_data;
  assign rsp_o.dirty_mask = head.dirty_mask;
  assign count_o          = cnt_q;

endmodule

// ===== rtl/floppy_controller_ports_core.sv =====
`timescale 1ns / 1ps
// Two-drive hard-sectored floppy controller behind three I/O ports.
// Uses fdc_pkg, fdc_if, fdc_image_ram and fdc_rsp_queue.
//
// Each request beat is one bus access (status/select, sector/function or
// data port) and yields exactly one response beat. After reset the image
// memories are filled with the blank pattern, one byte per drive per cycle
// in parallel, and req_i.ready stays low until the fill is done; APB writes
// are taken during that time. Afterwards one access is taken every cycle
// while the response queue has room. Register state updates at acceptance;
// a data-port read fetches its byte from the registered image memory read
// port, the byte is merged into the beat held in the s1 stage, and the beat
// is then pushed into the response queue. A four-entry response queue
// absorbs response-side stalls; after the fill, ready drops only when that
// queue plus the beat in flight fill it.
module floppy_controller_ports_core #(
  parameter int TRACK_COUNT  = fdc_pkg::TRACK_COUNT_DEF,
  parameter int SECTOR_COUNT = fdc_pkg::SECTOR_COUNT_DEF,
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdc_req_if.sink     req_i,
  fdc_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdc_pkg::*;

  localparam int DRIVE_BYTES  = TRACK_COUNT * SECTOR_COUNT * SECTOR_BYTES;
  localparam int ADDR_W       = $clog2(DRIVE_BYTES);
  localparam int TRACK_STRIDE = SECTOR_COUNT * SECTOR_BYTES;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // Architectural state
  logic [1:0]            sel_q, sel_d;
  logic                  phase_q, phase_d;
  logic [NUM_DRIVES-1:0] drive_present_q;
  drv_t                  drv_q [NUM_DRIVES];
  drv_t                  drv_d [NUM_DRIVES];

  // Pipeline stage between acceptance and the response queue
  logic                  s1_valid_q;
  logic                  s1_mem_q;
  logic                  s1_drive_q;
  rsp_t                  s1_rsp_q;

  // Access decode
  logic                  accept;
  logic                  cfg_we;
  logic                  d_idx;
  logic                  have_drive;
  logic                  present;
  drv_t                  cur;
  drv_t                  nxt;
  logic                  upd;
  logic [DATA_W-1:0]     rd;
  logic                  mem_re;
  logic                  mem_we;
  logic [TRACK_W-1:0]    eff_lt;
  logic [SECTOR_W-1:0]   eff_ls;
  logic [ADDR_W-1:0]     acc_addr;
  logic [TRACK_W-1:0]    step_trk;
  logic [7:0]            fn_st;
  logic [BPOS_W-1:0]     bpos_inc;
  logic [NUM_DRIVES-1:0] dirty;

  // Image memories and response queue
  logic [DATA_W-1:0]     img_rdata [NUM_DRIVES];
  logic [NUM_DRIVES-1:0] img_busy;
  logic                  clr_busy;
  logic [QPTR_W:0]       q_cnt;
  logic [QPTR_W:0]       occ;
  rsp_t                  push_data;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_DRIVE_PRESENT);
  assign prdata = (paddr[2] == REG_DRIVE_PRESENT) ? {30'd0, drive_present_q} : 32'd0;

  // Request handshake
  assign clr_busy    = |img_busy;
  assign occ         = q_cnt + (QPTR_W + 1)'(s1_valid_q);
  assign req_i.ready = !clr_busy && (occ < (QPTR_W + 1)'(QUEUE_DEPTH));
  assign accept      = req_i.valid && req_i.ready;

  // Selected drive register set
  assign d_idx      = sel_q[0];
  assign have_drive = (sel_q != SEL_NONE);
  assign cur        = drv_q[d_idx];
  assign present    = drive_present_q[d_idx];
  assign bpos_inc   = cur.bpos + 1'b1;

  // Byte address: position is latched at the first byte of a sector
  assign eff_lt   = (cur.bpos == '0) ? cur.track  : cur.ltrack;
  assign eff_ls   = (cur.bpos == '0) ? cur.sector : cur.lsector;
  assign acc_addr = ADDR_W'(eff_lt) * ADDR_W'(TRACK_STRIDE)
                  + ADDR_W'(eff_ls) * ADDR_W'(SECTOR_BYTES)
                  + ADDR_W'(cur.bpos);

  // Head stepping for the function port: in first, then out
  always_comb begin
    step_trk = cur.track;
    if (req_i.write_data[FN_IN_BIT] && (step_trk != TRACK_W'(TRACK_COUNT - 1))) begin
      step_trk = step_trk + 1'b1;
    end
    if (req_i.write_data[FN_OUT_BIT] && (step_trk != '0)) begin
      step_trk = step_trk - 1'b1;
    end
  end

  // Status update for the function port
  always_comb begin
    fn_st = cur.status;
    fn_st[ST_T0_BIT] = (step_trk == '0);
    if (req_i.write_data[FN_LOAD_BIT]) begin
      fn_st[ST_HEAD_BIT] = 1'b0;
      fn_st[ST_NRDA_BIT] = 1'b0;
      fn_st[ST_IE_BIT]   = 1'b1;
    end
    if (req_i.write_data[FN_UNLOAD_BIT]) begin
      fn_st[ST_HEAD_BIT] = 1'b1;
      fn_st[ST_NRDA_BIT] = 1'b1;
    end
    if (req_i.write_data[FN_IE_BIT]) begin
      fn_st[ST_IE_BIT] = 1'b1;
    end
    if (req_i.write_data[FN_ID_BIT]) begin
      fn_st[ST_IE_BIT] = 1'b0;
    end
  end

  // Access execution: next register set, read byte, memory request
  always_comb begin
    nxt     = cur;
    upd     = 1'b0;
    rd      = '0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    sel_d   = sel_q;
    phase_d = phase_q;
    if (req_i.operation == OP_IN) begin
      if (!have_drive) begin
        rd = IDLE_BYTE;
      end else begin
        case (req_i.port)
          PORT_SEL: begin
            rd = {~(~cur.status[ST_HEAD_BIT] & ~cur.wen), ~cur.status[ST_T0_BIT],
                  ~cur.status[ST_IE_BIT], 1'b1, ~cur.status[ST_CR_BIT],
                  cur.status[ST_HEAD_BIT], 2'b00};
          end
          PORT_SECT: begin
            upd = 1'b1;
            if (phase_q) begin
              phase_d = 1'b0;
            end else begin
              phase_d    = 1'b1;
              nxt.sector = (cur.sector == SECTOR_W'(SECTOR_COUNT - 1)) ? '0
                         : cur.sector + 1'b1;
              nxt.wen    = 1'b0;
              nxt.bpos   = '0;
            end
            rd = {SECT_HIGH, nxt.sector, phase_q};
          end
          PORT_DATA: begin
            if (!present) begin
              rd = IDLE_BYTE;
            end else begin
              upd         = 1'b1;
              nxt.ltrack  = eff_lt;
              nxt.lsector = eff_ls;
              if (cur.bpos >= BPOS_W'(SECTOR_BYTES)) begin
                rd = FILL_BYTE;
              end else begin
                mem_re   = 1'b1;
                nxt.bpos = bpos_inc;
              end
            end
          end
          default: rd = IDLE_BYTE;
        endcase
      end
    end else if (req_i.port == PORT_SEL) begin
      // Select ends any write on the old drive
      if (have_drive) begin
        upd      = 1'b1;
        nxt.wen  = 1'b0;
        nxt.bpos = '0;
      end
      if ((req_i.write_data[3:0] & SEL_FIELD_MASK) <= 4'd1) begin
        sel_d = {1'b0, req_i.write_data[0]};
      end else begin
        sel_d = SEL_NONE;
      end
    end else if (have_drive) begin
      case (req_i.port)
        PORT_SECT: begin
          upd = 1'b1;
          if (|req_i.write_data[FN_UNLOAD_BIT:FN_IN_BIT]) begin
            nxt.wen  = 1'b0;
            nxt.bpos = '0;
          end
          nxt.track  = step_trk;
          nxt.status = fn_st;
          if (req_i.write_data[FN_WE_BIT]) begin
            nxt.wen  = 1'b1;
            nxt.bpos = '0;
            nxt.modf = 1'b0;
          end
        end
        PORT_DATA: begin
          if (present && cur.wen) begin
            upd         = 1'b1;
            nxt.ltrack  = eff_lt;
            nxt.lsector = eff_ls;
            if (cur.bpos == '0) begin
              nxt.modf = 1'b1;
            end
            if (cur.bpos >= BPOS_W'(SECTOR_BYTES)) begin
              nxt.wen  = 1'b0;
              nxt.bpos = '0;
            end else begin
              mem_we   = 1'b1;
              nxt.modf = 1'b1;
              nxt.bpos = bpos_inc;
              if (bpos_inc >= BPOS_W'(SECTOR_BYTES)) begin
                nxt.wen  = 1'b0;
                nxt.bpos = '0;
              end
            end
          end
        end
        default: upd = 1'b0;
      endcase
    end
  end

  // Register set write-back
  always_comb begin
    drv_d = drv_q;
    if (upd) begin
      drv_d[d_idx] = nxt;
    end
    for (int k = 0; k < NUM_DRIVES; k++) begin
      dirty[k] = drv_d[k].modf;
    end
  end

  // Control and register-set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q           <= SEL_DRIVE0;
      phase_q         <= 1'b0;
      drive_present_q <= '1;
      s1_valid_q      <= 1'b0;
      for (int k = 0; k < NUM_DRIVES; k++) begin
        drv_q[k] <= DRV_RESET;
      end
    end else begin
      if (cfg_we) begin
        drive_present_q <= pwdata[NUM_DRIVES-1:0];
      end
      if (accept) begin
        sel_q   <= sel_d;
        phase_q <= phase_d;
        drv_q   <= drv_d;
      end
      s1_valid_q <= accept;
    end
  end

  // Response payload stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mem_q   <= mem_re;
      s1_drive_q <= d_idx;
      s1_rsp_q   <= '{read_data: rd, dirty_mask: dirty};
    end
  end

  // One image memory per drive
  for (genvar g = 0; g < NUM_DRIVES; g++) begin : g_img
    fdc_image_ram #(
      .Depth (DRIVE_BYTES)
    ) u_img (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (accept && mem_we && (d_idx == 1'(g))),
      .re_i    (accept && mem_re && (d_idx == 1'(g))),
      .addr_i  (acc_addr),
      .wdata_i (req_i.write_data),
      .rdata_o (img_rdata[g]),
      .busy_o  (img_busy[g])
    );
  end

  // Merge memory read data into the response beat
  always_comb begin
    push_data = s1_rsp_q;
    if (s1_mem_q) begin
      push_data.read_data = img_rdata[s1_drive_q];
    end
  end

  fdc_rsp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_rsp_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_data),
    .count_o     (q_cnt),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  // No access is taken while the images are being blanked
  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !req_i.ready)
    else $error("request accepted during image fill");

  // Every accepted beat reaches the response stage next cycle
  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted beat lost before response stage");

  // Image writes only happen with write enable on a present drive
  a_write_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_we) |-> (have_drive && cur.wen && present))
    else $error("image write without write enable");

  // Beats in flight never exceed queue capacity
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("response queue overflow");
`endif

endmodule
